### design/adcsa_pkg.sv
`timescale 1ns / 1ps
package adcsa_pkg;

	localparam int SAMPLE_W = 10;
	localparam int CHAN_W   = 4;
	localparam int MASK_W   = 16;

	localparam logic [MASK_W-1:0] MASK_RESET = 16'hFFFF;

	// per-item result fields that travel from the scan stage to the output stage
	typedef struct packed {
		logic [CHAN_W-1:0] mux_select;
		logic              sample_used;
		logic              average_valid;
		logic [CHAN_W-1:0] average_channel;
	} scan_res_t;

endpackage

### design/adcsa_scan.sv
`timescale 1ns / 1ps
module adcsa_scan #(
	parameter int SAMPLES  = 8,
	parameter int CHANNELS = 16,
	parameter int CNT_W    = 3,
	parameter int SUM_W    = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [adcsa_pkg::MASK_W-1:0]  cfg_wdata,
	input  logic                          adv,
	input  logic [adcsa_pkg::SAMPLE_W-1:0] sample_s1,
	input  logic [adcsa_pkg::CHAN_W-1:0]  chan_s1,
	output adcsa_pkg::scan_res_t          res_s2,
	output logic [SUM_W-1:0]              sum_s2
);
	import adcsa_pkg::*;

	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);

	logic [MASK_W-1:0] mask_q;
	logic [CHAN_W-1:0] scan_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;

	logic              match;
	logic              last;
	logic [SUM_W-1:0]  sum_acc;
	logic [CHAN_W-1:0] next_ch;
	scan_res_t         res_d;
	logic [SUM_W-1:0]  sum_d;

	// next active channel after the current one, wrapping; stays put on an empty mask
	always_comb begin
		logic [CHAN_W:0] cand;
		next_ch = scan_q;
		for (int i = CHANNELS; i >= 1; i--) begin
			cand = {1'b0, scan_q} + (CHAN_W+1)'(i);
			if (cand >= (CHAN_W+1)'(CHANNELS)) begin
				cand = cand - (CHAN_W+1)'(CHANNELS);
			end
			if (mask_q[cand[CHAN_W-1:0]]) begin
				next_ch = cand[CHAN_W-1:0];
			end
		end
	end

	always_comb begin
		match   = (chan_s1 == scan_q);
		// first sample of a channel is dropped
		sum_acc = sum_q + ((cnt_q != '0) ? SUM_W'(sample_s1) : '0);
		last    = match && (cnt_q == LAST_CNT);

		res_d.mux_select      = last ? next_ch : scan_q;
		res_d.sample_used     = match;
		res_d.average_valid   = last;
		res_d.average_channel = last ? scan_q : '0;
		sum_d                 = last ? sum_acc : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			cnt_q  <= '0;
			sum_q  <= '0;
		end else if (adv && match) begin
			if (last) begin
				scan_q <= next_ch;
				cnt_q  <= '0;
				sum_q  <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				sum_q <= sum_acc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
			sum_s2 <= sum_d;
		end
	end

endmodule

### design/adcsa_div.sv
`timescale 1ns / 1ps
module adcsa_div #(
	parameter int SUM_W   = 13,
	parameter int DIVISOR = 7
) (
	input  logic                           clk,
	input  logic                           load,
	input  adcsa_pkg::scan_res_t           res_s2,
	input  logic [SUM_W-1:0]               sum_s2,
	output adcsa_pkg::scan_res_t           res_s3,
	output logic [adcsa_pkg::SAMPLE_W-1:0] average_s3
);
	import adcsa_pkg::*;

	// exact reciprocal: floor(n * m / 2^shift) == floor(n / d) for every n below 2^SUM_W
	localparam int DIV_L     = $clog2(DIVISOR);
	localparam int DIV_SHIFT = SUM_W + DIV_L;
	localparam logic [SUM_W:0] DIV_MUL =
		(SUM_W+1)'(((longint'(1) << DIV_SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

	logic [2*SUM_W:0] prod;

	assign prod = {{(SUM_W+1){1'b0}}, sum_s2} * {{SUM_W{1'b0}}, DIV_MUL};

	always_ff @(posedge clk) begin
		if (load) begin
			res_s3     <= res_s2;
			average_s3 <= prod[DIV_SHIFT +: SAMPLE_W];
		end
	end

endmodule

### design/adc_scan_averager_core.sv
`timescale 1ns / 1ps
// a result reaches m_* through the input, scan and reciprocal-multiply registers
// throughput: one input per cycle unless m_tready stalls; a three-deep register pipeline
// (input register, scan state update, reciprocal multiply) with per-stage ready
// reset: arst_n low clears pipeline valids, scan channel, count and sum,
// and sets active_mask to all ones
module adc_scan_averager_core #(
	parameter int SAMPLES  = 8,
	parameter int CHANNELS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,    // active_mask
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,      // sample[9:0], converted_channel[13:10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,      // mux_select[3:0], average[13:4], average_channel[17:14]
	output logic [1:0]  m_tuser       // sample_used[0], average_valid[1]
);
	import adcsa_pkg::*;

	localparam int CNT_W = $clog2(SAMPLES);
	localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES - 1);

	logic                v1_q, v2_q, v3_q;
	logic                rdy1, rdy2, rdy3;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [CHAN_W-1:0]   chan_s1;
	scan_res_t           res_s2, res_s3;
	logic [SUM_W-1:0]    sum_s2;
	logic [SAMPLE_W-1:0] average_s3;

	// a stage takes new data when it is empty or its contents move on
	assign rdy3     = !v3_q || m_tready;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= s_tvalid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && rdy1) begin
			sample_s1 <= s_tdata[SAMPLE_W-1:0];
			chan_s1   <= s_tdata[SAMPLE_W +: CHAN_W];
		end
	end

	adcsa_scan #(
		.SAMPLES  (SAMPLES),
		.CHANNELS (CHANNELS),
		.CNT_W    (CNT_W),
		.SUM_W    (SUM_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.adv       (v1_q && rdy2),
		.sample_s1 (sample_s1),
		.chan_s1   (chan_s1),
		.res_s2    (res_s2),
		.sum_s2    (sum_s2)
	);

	adcsa_div #(
		.SUM_W   (SUM_W),
		.DIVISOR (SAMPLES - 1)
	) u_div (
		.clk        (clk),
		.load       (v2_q && rdy3),
		.res_s2     (res_s2),
		.sum_s2     (sum_s2),
		.res_s3     (res_s3),
		.average_s3 (average_s3)
	);

	assign m_tvalid = v3_q;
	assign m_tdata  = {6'b0, res_s3.average_channel, average_s3, res_s3.mux_select};
	assign m_tuser  = {res_s3.average_valid, res_s3.sample_used};

endmodule

### design/adcsa_checker.sv
`timescale 1ns / 1ps
module adcsa_checker #(
	parameter int CHANNELS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled result transaction holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	// an average is only produced by a counted sample
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("average without a used sample");

	// average and its channel read zero when no channel completed
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[17:4] == 14'd0)
		else $error("average fields set without average_valid");

	// the scan never leaves the configured channel range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> {1'b0, m_tdata[3:0]} < 5'(CHANNELS))
		else $error("mux select out of range");

endmodule

bind adc_scan_averager_core adcsa_checker #(.CHANNELS(CHANNELS)) u_adcsa_checker (.*);
